// ===== hw/rtl/gpt_pkg.sv =====
// ----------------------------------------------------------------------------
// gpt_pkg
// Shared types and constants of the gated period tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpt_pkg;

  localparam int unsigned DividendW = 64;
  localparam int unsigned DivisorW  = 32;
  localparam int unsigned PeriodW   = 32;
  localparam int unsigned StepCntW  = $clog2(DividendW);

  // Rounding constant of the (7*old + new + 4) / 8 blend.
  localparam logic [2:0] AvgRound = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BAND,
    ST_BLEND,
    ST_EMIT
  } gpt_state_e;

  typedef struct packed {
    logic div_start;
    logic band_en;
    logic blend_en;
    logic emit_en;
  } gpt_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gpt_div.sv =====
// ----------------------------------------------------------------------------
// gpt_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpt_div
  import gpt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [DividendW-1:0]      quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [StepCntW-1:0]  cnt_q, cnt_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [DivisorW:0]    rem_sh;
  logic [DivisorW:0]    diff;

  // The dividend shifts out of the top of quo_q while quotient bits enter
  // at the bottom, so one register holds both.
  assign rem_sh = {rem_q, quo_q[DividendW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[DivisorW]) begin
        rem_d = diff[DivisorW-1:0];
        quo_d = {quo_q[DividendW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DivisorW-1:0];
        quo_d = {quo_q[DividendW-2:0], 1'b0};
      end
      cnt_d = cnt_q - StepCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gated_period_tracker_unit.sv =====
// An input transaction starts the bit-serial divider; the quotient then passes
// the band and blend states, and emit waits while the output is stalled.
// No new input is taken until the previous result has been emitted.
// A new input is taken while a finished result still waits at the output.
// Reset clears the nominal period and the stored estimate (no estimate yet).
// ----------------------------------------------------------------------------
// gated_period_tracker_unit
// Divides elapsed ticks by report count, gates the observed period against
// a band around the nominal period and blends it into a running estimate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gated_period_tracker_unit
  import gpt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [PeriodW-1:0]   cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [DividendW-1:0] elapsed_ticks_i,
  input  wire logic [DivisorW-1:0]  report_count_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [PeriodW-1:0]        period_estimate_o
);

  gpt_state_e state_q, state_d;
  gpt_ctrl_t  ctrl;

  logic [PeriodW-1:0]   nominal_q;
  logic [PeriodW-1:0]   lo_q;
  logic [PeriodW:0]     hi_q;
  logic [PeriodW+1:0]   nom_x3;
  logic [PeriodW+2:0]   nom_x5;
  logic [PeriodW-1:0]   stored_q;
  logic                 cnt_zero_q;
  logic                 use_obs_q;
  logic [PeriodW+2:0]   keep7_q;
  logic [PeriodW-1:0]   fallback_q;
  logic [PeriodW-1:0]   obs_q;
  logic [PeriodW-1:0]   res_q;
  logic [PeriodW+3:0]   blend_sum;
  logic [PeriodW-1:0]   res_d;
  logic                 out_valid_q;
  logic [PeriodW-1:0]   out_q;
  logic                 div_done;
  logic [DividendW-1:0] quotient;
  logic                 in_acc;
  logic                 emit_ok;
  logic                 obs_ok;

  assign in_acc  = in_valid_i && (state_q == ST_IDLE);
  assign emit_ok = !out_valid_q || !out_stall_i;

  gpt_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (ctrl.div_start),
    .dividend_i (elapsed_ticks_i),
    .divisor_i  (report_count_i),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Band limits are fixed between configuration writes, so they are
  // precomputed when the nominal period is written.
  assign nom_x3 = {1'b0, cfg_wdata_i, 1'b0} + {2'b00, cfg_wdata_i};
  assign nom_x5 = {1'b0, cfg_wdata_i, 2'b00} + {3'b000, cfg_wdata_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
    end else if (cfg_we_i) begin
      nominal_q <= cfg_wdata_i;
      lo_q      <= nom_x3[PeriodW+1:2];
      hi_q      <= nom_x5[PeriodW+2:2];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_BAND;
      ST_BAND:  state_d = ST_BLEND;
      ST_BLEND: state_d = ST_EMIT;
      ST_EMIT:  if (emit_ok) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE:  ctrl.div_start = in_valid_i;
      ST_DIV:   ctrl         = '0;
      ST_BAND:  ctrl.band_en  = 1'b1;
      ST_BLEND: ctrl.blend_en = 1'b1;
      ST_EMIT:  ctrl.emit_en  = emit_ok;
      default:  ctrl         = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign obs_ok = !cnt_zero_q && (nominal_q != '0)
               && (quotient[DividendW-1:PeriodW] == '0)
               && (quotient[PeriodW-1:0] >= lo_q)
               && ({1'b0, quotient[PeriodW-1:0]} <= hi_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cnt_zero_q <= (report_count_i == '0);
    end
    if (ctrl.band_en) begin
      use_obs_q  <= obs_ok;
      obs_q      <= quotient[PeriodW-1:0];
      keep7_q    <= {stored_q, 3'b000} - {3'b000, stored_q};
      fallback_q <= (stored_q != '0) ? stored_q : nominal_q;
    end
  end

  assign blend_sum = {1'b0, keep7_q} + {4'b0000, obs_q} + {{(PeriodW+1){1'b0}}, AvgRound};

  always_comb begin
    if (!use_obs_q) begin
      res_d = fallback_q;
    end else if (keep7_q == '0) begin
      // No estimate yet: the observation is loaded as it is.
      res_d = obs_q;
    end else begin
      res_d = blend_sum[PeriodW+2:3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0;
    end else if (ctrl.blend_en) begin
      stored_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.blend_en) begin
      res_q <= res_d;
    end
    if (ctrl.emit_en) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign period_estimate_o = out_q;

endmodule

`default_nettype wire

// ===== tb/tb_gated_period_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_gated_period_tracker_unit
// Self-checking bench for the gated period tracker. A directed table covers
// the band edges, zero counts, a zero nominal period, 32-bit overflow of the
// observation and the zero-estimate case. Random phases follow, each with its
// own nominal period. Results are held to literals or an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gated_period_tracker_unit;
  import gpt_pkg::*;

  localparam int unsigned ItemsPerPhase = 105;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned HoldAfter     = 150;
  localparam int unsigned WatchdogLimit = 3000;

  // Band and blend constants of the tracker.
  localparam logic [63:0] BandLoNum = 64'd3;
  localparam logic [63:0] BandHiNum = 64'd5;
  localparam logic [63:0] BandDen   = 64'd4;
  localparam logic [63:0] KeepW     = 64'd7;
  localparam logic [63:0] AvgDen    = 64'd8;
  localparam logic [63:0] AvgRnd    = 64'(AvgRound);

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [63:0] elapsed;
    logic [31:0] value;
    logic        has_lit;
    logic [31:0] lit;
  } row_t;

  localparam logic [63:0] AllOnes64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] AllOnes32 = 32'hFFFF_FFFF;

  // For items, value is the report count; for register writes, the nominal period.
  localparam row_t DirectedRows [22] = '{
    '{ROW_ITEM, 64'd1000,      32'd10,      1'b1, 32'd0},
    '{ROW_ITEM, 64'd0,         32'd0,       1'b1, 32'd0},
    '{ROW_ITEM, AllOnes64,     AllOnes32,   1'b1, 32'd0},
    '{ROW_CFG,  64'd0,         32'd1,       1'b0, 32'd0},
    '{ROW_ITEM, 64'd0,         32'd5,       1'b1, 32'd0},
    '{ROW_ITEM, 64'd3,         32'd3,       1'b1, 32'd1},
    '{ROW_ITEM, 64'd7,         32'd3,       1'b1, 32'd1},
    '{ROW_CFG,  64'd0,         32'd1000,    1'b0, 32'd0},
    '{ROW_ITEM, 64'd10000,     32'd10,      1'b0, 32'd0},
    '{ROW_ITEM, 64'd12500,     32'd10,      1'b0, 32'd0},
    '{ROW_ITEM, 64'd12510,     32'd10,      1'b0, 32'd0},
    '{ROW_ITEM, 64'd7500,      32'd10,      1'b0, 32'd0},
    '{ROW_ITEM, 64'd7499,      32'd10,      1'b0, 32'd0},
    '{ROW_ITEM, 64'd123,       32'd0,       1'b0, 32'd0},
    '{ROW_CFG,  64'd0,         32'd0,       1'b0, 32'd0},
    '{ROW_ITEM, 64'd10000,     32'd10,      1'b0, 32'd0},
    '{ROW_CFG,  64'd0,         AllOnes32,   1'b0, 32'd0},
    '{ROW_ITEM, 64'h1_0000_0000, 32'd1,     1'b0, 32'd0},
    '{ROW_ITEM, 64'hFFFF_FFFF, 32'd1,       1'b0, 32'd0},
    '{ROW_ITEM, AllOnes64,     AllOnes32,   1'b0, 32'd0},
    '{ROW_ITEM, AllOnes64,     32'd1,       1'b0, 32'd0},
    '{ROW_ITEM, 64'd0,         AllOnes32,   1'b0, 32'd0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [PeriodW-1:0]   cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [DividendW-1:0] elapsed_ticks_i = '0;
  logic [DivisorW-1:0]  report_count_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PeriodW-1:0]   period_estimate_o;

  // Predictor state: nominal period register and the running estimate.
  logic [31:0] trk_nominal = '0;
  logic [31:0] trk_estimate = '0;
  logic [31:0] estimate_q [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  bit          no_idle = 1'b0;

  gated_period_tracker_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .elapsed_ticks_i   (elapsed_ticks_i),
    .report_count_i    (report_count_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .period_estimate_o (period_estimate_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] next_estimate(input logic [63:0] el, input logic [31:0] cnt);
    logic [63:0] obs;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mix;
    logic [31:0] fallback;
    fallback = (trk_estimate != 0) ? trk_estimate : trk_nominal;
    if (cnt == 0 || trk_nominal == 0) return fallback;
    obs = el / {32'd0, cnt};
    lo = {32'd0, trk_nominal} * BandLoNum / BandDen;
    hi = {32'd0, trk_nominal} * BandHiNum / BandDen;
    if (obs < lo || obs > hi || obs > 64'hFFFF_FFFF) return fallback;
    if (trk_estimate == 0) return obs[31:0];
    mix = ({32'd0, trk_estimate} * KeepW + obs + AvgRnd) / AvgDen;
    return mix[31:0];
  endfunction

  // Offers one transaction and records its expected estimate once accepted.
  task automatic send_item(input logic [63:0] el, input logic [31:0] cnt,
                           input bit use_lit, input logic [31:0] lit);
    logic [31:0] nxt;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    elapsed_ticks_i <= el;
    report_count_i <= cnt;
    do @(posedge clk_i); while (in_stall_o);
    nxt = next_estimate(el, cnt);
    trk_estimate = nxt;
    estimate_q.push_back(use_lit ? lit : nxt);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (estimate_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_nominal(input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    trk_nominal = val;
  endtask

  // Stimulus.
  initial begin
    row_t        row;
    logic [63:0] el;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] obs;
    logic [63:0] span;
    logic [31:0] cnt;
    logic [31:0] nom;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 22; i++) begin
      row = DirectedRows[i];
      if (row.kind == ROW_CFG) begin
        drain();
        write_nominal(row.value);
      end else begin
        send_item(row.elapsed, row.value, row.has_lit, row.lit);
      end
    end

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       nom = 32'd1000;
        1:       nom = 32'd1;
        2:       nom = AllOnes32;
        3:       nom = $urandom_range(2, 64);
        4:       nom = $urandom;
        5:       nom = 32'd0;
        6:       nom = 32'd1_000_000;
        default: nom = $urandom;
      endcase
      drain();
      write_nominal(nom);
      no_idle = (ph == NumPhases - 1);
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        lo = {32'd0, trk_nominal} * BandLoNum / BandDen;
        hi = {32'd0, trk_nominal} * BandHiNum / BandDen;
        case ($urandom_range(0, 9))
          0: begin
            el = {$urandom, $urandom};
            cnt = $urandom;
          end
          1: begin
            el = {$urandom, $urandom};
            cnt = '0;
          end
          2: begin
            el = {$urandom, $urandom};
            cnt = $urandom_range(1, 3);
          end
          default: begin
            // Well-formed interval: an observation near or inside the band.
            case ($urandom_range(0, 7))
              0: obs = lo;
              1: obs = hi;
              2: obs = hi + 1;
              3: obs = (lo == 0) ? 64'd0 : lo - 1;
              default: begin
                span = (hi + hi / 4 + 1) - (lo - lo / 4);
                obs = (lo - lo / 4) + ({$urandom, $urandom} % (span + 1));
              end
            endcase
            cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1 << 20)
                                              : $urandom_range(1, 16);
            el = obs * {32'd0, cnt} + {32'd0, $urandom % cnt};
          end
        endcase
        send_item(el, cnt, 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_gated_period_tracker_unit passed");
    end else begin
      $display("tb_gated_period_tracker_unit failed");
    end
    $finish;
  end

  // Result side: checks each accepted transaction and drives the stall.
  initial begin
    int unsigned stall_left;
    logic [31:0] want;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (estimate_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, got %0d", $time, period_estimate_o);
        end else begin
          want = estimate_q.pop_front();
          if (period_estimate_o !== want) begin
            mismatches++;
            $display("%0t: period_estimate mismatch, expected %0d, got %0d",
                     $time, want, period_estimate_o);
          end
        end
      end
      // One long hold-off lets the block fill up and stall its input.
      if (results_seen == HoldAfter && stall_left == 0 && !no_idle) begin
        results_seen++;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(1, 4) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run after a long stretch without any transaction.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
        $display("tb_gated_period_tracker_unit failed");
        $finish;
      end
    end
  end

endmodule
